/* hdl/assert_macros.svh */
// Assertion helpers used by swm_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of aclk outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on every rising edge of aclk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hdl/swm_pkg.sv */
package swm_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_BITS  = 16;
    localparam int CFG_BITS     = 7;
    localparam int IDX_BITS     = $clog2(WINDOW_MAX);
    localparam int CNT_BITS     = $clog2(WINDOW_MAX + 1);
    localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((SAMPLE_BITS + 1 + 7) / 8) * 8;
    localparam int WIN_RESET    = 3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SAMPLE_BITS:0]   twice_t;
    typedef logic [CNT_BITS-1:0]           cnt_t;
    typedef logic [IDX_BITS-1:0]           idx_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_LOAD   = 7'b0000010,
        ST_REMOVE = 7'b0000100,
        ST_INSERT = 7'b0001000,
        ST_MED_LO = 7'b0010000,
        ST_MED_HI = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic capture;
        logic cfg_write;
        logic load;
        logic remove;
        logic insert;
        logic med_lo;
        logic med_hi;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic last;
        logic out_busy;
    } stat_t;

    function automatic cnt_t win_eff(input logic [CFG_BITS-1:0] value);
        cnt_t res;
        if (value == '0) begin
            res = cnt_t'(1);
        end else if (int'(value) > WINDOW_MAX) begin
            res = cnt_t'(WINDOW_MAX);
        end else begin
            res = cnt_t'(value);
        end
        return res;
    endfunction

endpackage

/* hdl/swm_ctrl.sv */
module swm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  swm_pkg::stat_t stat,
    output swm_pkg::cmd_t  cmd
);

    swm_pkg::state_t state_reg;
    swm_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= swm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        cfg_ready  = 1'b0;
        case (state_reg)
            swm_pkg::ST_IDLE: begin
                s_tready      = 1'b1;
                cfg_ready     = 1'b1;
                cmd.capture   = s_tvalid;
                cmd.cfg_write = cfg_valid;
                if (s_tvalid) begin
                    state_next = swm_pkg::ST_LOAD;
                end
            end
            swm_pkg::ST_LOAD: begin
                cmd.load = 1'b1;
                if (stat.full) begin
                    state_next = swm_pkg::ST_REMOVE;
                end else if (stat.last) begin
                    state_next = swm_pkg::ST_MED_LO;
                end else begin
                    state_next = swm_pkg::ST_IDLE;
                end
            end
            swm_pkg::ST_REMOVE: begin
                cmd.remove = 1'b1;
                state_next = swm_pkg::ST_INSERT;
            end
            swm_pkg::ST_INSERT: begin
                cmd.insert = 1'b1;
                state_next = swm_pkg::ST_MED_LO;
            end
            swm_pkg::ST_MED_LO: begin
                cmd.med_lo = 1'b1;
                state_next = swm_pkg::ST_MED_HI;
            end
            swm_pkg::ST_MED_HI: begin
                cmd.med_hi = 1'b1;
                state_next = swm_pkg::ST_EMIT;
            end
            swm_pkg::ST_EMIT: begin
                if (!stat.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = swm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = swm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/swm_datapath.sv */
module swm_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  swm_pkg::cmd_t                      cmd,
    output swm_pkg::stat_t                     stat,
    input  logic [swm_pkg::S_TDATA_BITS-1:0]   s_tdata,
    input  logic                               s_tuser,
    input  logic [swm_pkg::CFG_BITS-1:0]       cfg_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [swm_pkg::M_TDATA_BITS-1:0]   m_tdata
);

    swm_pkg::sample_t ring_mem [swm_pkg::WINDOW_MAX];
    swm_pkg::sample_t cell_reg [swm_pkg::WINDOW_MAX];
    swm_pkg::sample_t cell_next [swm_pkg::WINDOW_MAX];
    logic [swm_pkg::WINDOW_MAX-1:0] ge_rm;
    logic [swm_pkg::WINDOW_MAX-1:0] gt_x;

    swm_pkg::sample_t x_reg;
    logic             rst_reg;
    swm_pkg::sample_t rd_reg;
    swm_pkg::sample_t lo_reg;
    swm_pkg::twice_t  sum_reg;
    logic [swm_pkg::SAMPLE_BITS:0] m_data_reg;
    logic             m_valid_reg;
    logic             m_valid_next;

    swm_pkg::cnt_t win_reg;
    swm_pkg::cnt_t win_next;
    swm_pkg::cnt_t fill_reg;
    swm_pkg::cnt_t fill_next;
    swm_pkg::idx_t oldest_reg;
    swm_pkg::idx_t oldest_next;

    swm_pkg::cnt_t fill_eff;
    swm_pkg::cnt_t ins_n;
    swm_pkg::cnt_t half;
    swm_pkg::cnt_t oldest_inc;
    swm_pkg::idx_t lo_idx;
    swm_pkg::idx_t hi_idx;
    swm_pkg::idx_t ring_waddr;
    logic          ring_we;
    logic          do_insert;

    assign fill_eff   = rst_reg ? '0 : fill_reg;
    assign stat.full  = (fill_eff == win_reg);
    assign stat.last  = ((fill_eff + swm_pkg::cnt_t'(1)) == win_reg);
    assign stat.out_busy = m_valid_reg && !m_tready;

    assign do_insert  = (cmd.load && !stat.full) || cmd.insert;
    assign ins_n      = cmd.load ? fill_eff : (win_reg - swm_pkg::cnt_t'(1));
    assign half       = win_reg >> 1;
    assign hi_idx     = half[swm_pkg::IDX_BITS-1:0];
    assign lo_idx     = win_reg[0] ? hi_idx : (hi_idx - swm_pkg::idx_t'(1));
    assign oldest_inc = swm_pkg::cnt_t'(oldest_reg) + swm_pkg::cnt_t'(1);

    assign ring_we    = (cmd.load && !stat.full) || cmd.insert;
    assign ring_waddr = cmd.insert ? oldest_reg : fill_eff[swm_pkg::IDX_BITS-1:0];

    // one compare pair per slot; sorted order turns "first copy" into ">="
    always_comb begin
        for (int j = 0; j < swm_pkg::WINDOW_MAX; j++) begin
            ge_rm[j]     = (cell_reg[j] >= rd_reg);
            gt_x[j]      = (swm_pkg::cnt_t'(j) < ins_n) && (cell_reg[j] > x_reg);
            cell_next[j] = cell_reg[j];
            if (cmd.remove && (j < swm_pkg::WINDOW_MAX - 1)) begin
                if (((swm_pkg::cnt_t'(j) + swm_pkg::cnt_t'(1)) < win_reg) && ge_rm[j]) begin
                    cell_next[j] = cell_reg[j+1];
                end
            end
        end
        if (do_insert) begin
            for (int j = 0; j < swm_pkg::WINDOW_MAX; j++) begin
                if (gt_x[j] || (swm_pkg::cnt_t'(j) == ins_n)) begin
                    cell_next[j] = x_reg;
                    if (j > 0) begin
                        if (gt_x[j-1]) begin
                            cell_next[j] = cell_reg[j-1];
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        win_next    = win_reg;
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        if (cmd.cfg_write) begin
            win_next    = swm_pkg::win_eff(cfg_data);
            fill_next   = '0;
            oldest_next = '0;
        end else if (cmd.load && !stat.full) begin
            fill_next   = fill_eff + swm_pkg::cnt_t'(1);
            oldest_next = '0;
        end else if (cmd.insert) begin
            oldest_next = (oldest_inc == win_reg) ? '0
                                                  : oldest_inc[swm_pkg::IDX_BITS-1:0];
        end
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= swm_pkg::cnt_t'(swm_pkg::WIN_RESET);
            fill_reg    <= '0;
            oldest_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            win_reg     <= win_next;
            fill_reg    <= fill_next;
            oldest_reg  <= oldest_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= x_reg;
        end
        if (cmd.load) begin
            rd_reg <= ring_mem[oldest_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg   <= swm_pkg::sample_t'(s_tdata[swm_pkg::SAMPLE_BITS-1:0]);
            rst_reg <= s_tuser;
        end
        for (int j = 0; j < swm_pkg::WINDOW_MAX; j++) begin
            cell_reg[j] <= cell_next[j];
        end
        if (cmd.med_lo) begin
            lo_reg <= cell_reg[lo_idx];
        end
        if (cmd.med_hi) begin
            sum_reg <= swm_pkg::twice_t'(lo_reg) + swm_pkg::twice_t'(cell_reg[hi_idx]);
        end
        if (cmd.emit) begin
            m_data_reg <= sum_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = swm_pkg::M_TDATA_BITS'(m_data_reg);

endmodule

/* hdl/sliding_window_median.sv */
// Running median over the last window_size samples (1 to 64).
// Input transfer: s_tdata carries the signed sample, s_tuser the restart
// flag, which empties the window before its sample is taken.
// Output transfer: m_tdata[16:0] carries twice the median (sum of the two
// middle values for an even window), upper bits zero. No result is given
// until the window is full.
// cfg_data sets window_size (0 reads as 1, above 64 as 64); a write also
// empties the window. Write it only while no sample is in flight.
// Timing: a sample that leaves the window short goes through LOAD only;
// once full: LOAD, REMOVE, INSERT, MED_LO, MED_HI, EMIT before the next;
// m_tvalid rises after EMIT. The shared per-slot compare row drops the
// oldest in REMOVE, inserts the new one in INSERT; then two tap reads.
// A result waits in the output register while m_tready is low; the next
// sample is still taken, and its result holds until the register frees.
// Reset: window size 3, window empty, no result pending.
module sliding_window_median (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [swm_pkg::S_TDATA_BITS-1:0] s_tdata,  // [15:0] sample
    input  logic                             s_tuser,  // [0] restart
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [swm_pkg::M_TDATA_BITS-1:0] m_tdata,  // [16:0] median_twice
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [swm_pkg::CFG_BITS-1:0]     cfg_data
);

    swm_pkg::cmd_t  cmd;
    swm_pkg::stat_t stat;

    swm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    swm_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* hdl/swm_checker.sv */
`include "assert_macros.svh"

module swm_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [swm_pkg::M_TDATA_BITS-1:0] m_tdata,
    input logic                             cfg_ready
);

    `ASSERT_CLK(a_m_valid_hold, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped")
    `ASSERT_CLK(a_m_data_hold, m_tvalid && !m_tready |=> $stable(m_tdata), "m_tdata moved")
    `ASSERT_CLK(a_busy_after_in, s_tvalid && s_tready |=> !s_tready && !cfg_ready, "ready held")
    `ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid, "result pending after reset")

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);

/* sim/median_checker.sv */
`timescale 1ns / 100ps

module median_checker
    import swm_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,  // [15:0] sample
    input  logic                    s_tuser,  // [0] restart
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [M_TDATA_BITS-1:0] m_tdata,  // [16:0] median_twice
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_BITS-1:0]     cfg_data,
    output int                      fail_cnt,
    output int                      pending_cnt,
    output int                      checked_cnt
);

    logic [CFG_BITS-1:0] win_setting;
    sample_t             arrival [WINDOW_MAX];
    sample_t             ordered [WINDOW_MAX];
    int                  fill;
    int                  oldest;
    int                  mismatches;
    int                  checked;
    int                  accepted;
    twice_t              median_q [$];

    function automatic int window_len();
        int w;
        w = int'(win_setting);
        if (w == 0) begin
            w = 1;
        end else if (w > WINDOW_MAX) begin
            w = WINDOW_MAX;
        end
        return w;
    endfunction

    function automatic void drop_value(input sample_t v, input int n);
        int i;
        i = 0;
        while (i + 1 < n && ordered[i] != v) begin
            i++;
        end
        for (; i + 1 < n; i++) begin
            ordered[i] = ordered[i + 1];
        end
    endfunction

    function automatic void place_value(input sample_t v, input int n);
        int i;
        i = n;
        while (i > 0 && ordered[i - 1] > v) begin
            ordered[i] = ordered[i - 1];
            i--;
        end
        ordered[i] = v;
    endfunction

    function automatic bit median_step(input sample_t x, input logic restart,
                                       output twice_t med);
        int w;
        int p;
        int s;
        w = window_len();
        med = '0;
        if (restart) begin
            fill   = 0;
            oldest = 0;
        end
        if (fill < w) begin
            arrival[fill] = x;
            place_value(x, fill);
            fill++;
            if (fill < w) begin
                return 1'b0;
            end
            oldest = 0;
        end else begin
            p = oldest % w;
            drop_value(arrival[p], w);
            place_value(x, w - 1);
            arrival[p] = x;
            oldest = (p + 1) % w;
        end
        if (w % 2 == 1) begin
            s = 2 * int'(ordered[w / 2]);
        end else begin
            s = int'(ordered[w / 2 - 1]) + int'(ordered[w / 2]);
        end
        med = twice_t'(s);
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        twice_t med;
        twice_t want;
        twice_t got;
        if (!aresetn) begin
            win_setting = CFG_BITS'(WIN_RESET);
            fill        = 0;
            oldest      = 0;
            median_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                win_setting = cfg_data;
                fill        = 0;
                oldest      = 0;
            end
            if (s_tvalid && s_tready) begin
                accepted++;
                if (median_step(sample_t'(s_tdata[SAMPLE_BITS-1:0]), s_tuser, med)) begin
                    median_q = {median_q, med};
                end
            end
            if (m_tvalid && m_tready) begin
                got = twice_t'(m_tdata[SAMPLE_BITS:0]);
                if (median_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("median_twice transfer %0d with nothing expected",
                                 got);
                    end
                    mismatches++;
                end else begin
                    want = median_q.pop_front();
                    checked++;
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("median_twice after %0d samples: expected %0d, got %0d",
                                     accepted, want, got);
                        end
                        mismatches++;
                    end
                end
            end
        end
        fail_cnt    <= mismatches;
        pending_cnt <= median_q.size();
        checked_cnt <= checked;
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import swm_pkg::*;

    localparam int POST_IDLE   = 16;
    localparam int DRAIN_LIMIT = 4000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASES      = 12;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata;  // [15:0] sample
    logic                    s_tuser;  // [0] restart
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_BITS-1:0] m_tdata;  // [16:0] median_twice
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_BITS-1:0]     cfg_data;

    int fail_cnt;
    int pending_cnt;
    int checked_cnt;
    int items_sent;
    int burst_left;
    bit hold_req;

    int win_plan [PHASES]  = '{1, 0, 64, 2, 127, 5, 4, 65, 8, 17, 32, 3};
    int item_plan [PHASES] = '{120, 80, 300, 150, 200, 250, 150, 150, 150, 150, 100, 150};

    sliding_window_median DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    median_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_cnt    (fail_cnt),
        .pending_cnt (pending_cnt),
        .checked_cnt (checked_cnt)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #12_000_000;
        $display("[sliding_window_median] ERROR");
        $finish;
    end

    // Receiver: stretches of steady, random, sparse and periodic acceptance.
    initial begin
        int mode;
        int span;
        int tick;
        m_tready = 1'b0;
        tick     = 0;
        wait (aresetn);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            for (int k = 0; k < span; k++) begin
                if (hold_req) begin
                    hold_req = 1'b0;
                    m_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                end
                case (mode)
                    0: begin
                        m_tready <= 1'b1;
                    end
                    1: begin
                        m_tready <= $urandom_range(0, 1);
                    end
                    2: begin
                        m_tready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_tready <= (tick % 3 != 0);
                    end
                endcase
                tick++;
                @(posedge aclk);
            end
        end
    end

    function automatic sample_t pick_sample();
        sample_t v;
        case ($urandom_range(0, 9))
            0: v = sample_t'(16'h7fff);
            1: v = sample_t'(16'h8000);
            2, 3: v = sample_t'($urandom_range(0, 6) - 3);
            default: v = sample_t'($urandom);
        endcase
        return v;
    endfunction

    task automatic offer(input sample_t smp, input logic rst);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_BITS'(smp);
        s_tuser  <= rst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
                5, 6, 7: gap = 0;
                8: gap = $urandom_range(4, 12);
                default: gap = $urandom_range(20, 40);
            endcase
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                      : $urandom_range(1, 16);
        end
    endtask

    // Hold the input until every pending median has been taken, then idle.
    task automatic settle();
        int waited;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        waited = 0;
        while (pending_cnt != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (POST_IDLE) @(posedge aclk);
    endtask

    task automatic write_window(input int setting);
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_BITS'(setting);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int eff;
        int odds;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        hold_req   = 1'b0;
        items_sent = 0;
        burst_left = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset window of three: extremes, equal values, restart.
        offer(16'sh7fff, 1'b0);
        offer(16'sh8000, 1'b0);
        offer(16'sh0000, 1'b0);
        offer(-16'sd1, 1'b0);
        offer(16'sd1, 1'b0);
        offer(16'sh7fff, 1'b0);
        offer(16'sh7fff, 1'b0);
        offer(16'sh7fff, 1'b0);
        offer(16'sh8000, 1'b0);
        offer(16'sh8000, 1'b0);
        offer(16'sh8000, 1'b0);
        offer(16'sd5, 1'b1);
        offer(16'sd5, 1'b0);
        offer(-16'sd7, 1'b0);
        offer(16'sh5555, 1'b0);
        offer(16'shaaaa, 1'b1);
        offer(16'sh0000, 1'b0);
        offer(-16'sd1, 1'b0);
        settle();

        // Even window: sums at both ends of the range.
        write_window(2);
        offer(16'sh7fff, 1'b0);
        offer(16'sh7fff, 1'b0);
        offer(16'sh8000, 1'b0);
        offer(16'sh8000, 1'b0);
        offer(16'sh0000, 1'b1);
        offer(16'sd1, 1'b0);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_window(win_plan[ph]);
            eff = int'(CFG_BITS'(win_plan[ph]));
            if (eff == 0) begin
                eff = 1;
            end else if (eff > WINDOW_MAX) begin
                eff = WINDOW_MAX;
            end
            odds = 8 * eff + 20;
            if (win_plan[ph] == 5) begin
                hold_req   = 1'b1;
                burst_left = 300;
            end
            for (int n = 0; n < item_plan[ph]; n++) begin
                offer(pick_sample(), ($urandom_range(0, odds - 1) == 0));
            end
            settle();
        end

        $display("covered %0d samples over window settings 0 to 127, %0d medians checked,",
                 items_sent, checked_cnt);
        $display("with restarts, saturated sizes, idle gaps and a long output stall");
        if (pending_cnt != 0) begin
            $display("%0d expected medians never arrived", pending_cnt);
        end
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("[sliding_window_median] OK");
        end else begin
            $display("[sliding_window_median] ERROR");
        end
        $finish;
    end

endmodule
